// File: hdl/matrix_vector_multiply_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the matrix-vector multiply
// Shared forms of the concurrent checks, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_MULTIPLY_MACROS_SVH
`define MATRIX_VECTOR_MULTIPLY_MACROS_SVH

// Same-cycle implication.
`define MVM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MVM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/mvm_pkg.sv
// ----------------------------------------------------------------------------
// Matrix-vector multiply package
// Sizes, field positions, codes and the types passed between the modules.
// ----------------------------------------------------------------------------
package mvm_pkg;

	localparam int MAX_COLS    = 1024;
	localparam int VALUE_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int ACC_W       = 64;

	localparam int FIELD_W     = 32;
	localparam int IDX_W       = 10;
	localparam int ROW_W       = 16;
	localparam int COLS_CFG_W  = 11;
	localparam int CFG_W       = 16;
	localparam int COLS_RESET  = 1024;
	localparam int ROWS_RESET  = 1;

	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int CNT_W  = $clog2(MAX_COLS + 1);
	localparam int CMP_W  = (COLS_CFG_W > CNT_W) ? COLS_CFG_W : CNT_W;

	localparam int S_TDATA_W  = 48;
	localparam int IDX_LSB    = 0;
	localparam int VAL_LSB    = IDX_LSB + IDX_W;
	localparam int M_TDATA_W  = 48;
	localparam int ROWSUM_LSB = 0;
	localparam int ROWNUM_LSB = ROWSUM_LSB + FIELD_W;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [0:0] {
		REG_COLS = 1'b0,
		REG_ROWS = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		CMD_VECTOR = 1'b0,
		CMD_MATRIX = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [COLS_CFG_W-1:0] cols;
		logic [ROW_W-1:0]      rows;
		logic                  clear;
	} mvm_cfg_t;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] elem;
		logic [VALUE_WIDTH-1:0] vec;
		logic                   end_row;
		logic [ROW_W-1:0]       row;
		logic                   last;
	} mvm_op_t;

endpackage

// File: hdl/mvm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mvm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/mvm_front.sv
// ----------------------------------------------------------------------------
// Matrix-vector multiply front end
// Accepts words, writes vector elements into the store and turns matrix
// elements into multiply operations with their column and row bookkeeping.
// ----------------------------------------------------------------------------
module mvm_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mvm_pkg::mvm_cfg_t              cfg,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [mvm_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic                           s_tuser,
	input  logic [mvm_pkg::QCNT_W-1:0]     q_count,
	output logic                           push,
	output mvm_pkg::mvm_op_t               push_op
);
	import mvm_pkg::*;

	logic                   accept;
	logic                   is_mat;
	logic [IDX_W-1:0]       idx;
	logic [VALUE_WIDTH-1:0] elem;
	logic                   wr_en;
	logic                   rd_en;
	logic [VALUE_WIDTH-1:0] rdata;
	logic [CMP_W-1:0]       cols_wide;
	logic [CMP_W-1:0]       cols_eff;
	logic [ROW_W-1:0]       rows_eff;
	logic                   end_row;
	logic                   last;

	logic [COL_W-1:0]       col_q;
	logic [ROW_W-1:0]       row_q;
	logic                   op_valid_s1;
	logic [VALUE_WIDTH-1:0] elem_s1;
	logic                   end_row_s1;
	logic [ROW_W-1:0]       row_s1;
	logic                   last_s1;

	assign s_tready = ((QCNT_W+1)'(q_count) + (QCNT_W+1)'(op_valid_s1))
		< (QCNT_W+1)'(QDEPTH);
	assign accept = s_tvalid && s_tready;
	assign is_mat = (cmd_t'(s_tuser) == CMD_MATRIX);
	assign idx    = s_tdata[IDX_LSB +: IDX_W];
	assign elem   = s_tdata[VAL_LSB +: VALUE_WIDTH];
	assign wr_en  = accept && !is_mat && (32'(idx) < MAX_COLS);
	assign rd_en  = accept && is_mat;

	always_comb begin
		cols_wide = CMP_W'(cfg.cols);
		if (cols_wide == '0) begin
			cols_eff = CMP_W'(1);
		end else if (cols_wide > CMP_W'(MAX_COLS)) begin
			cols_eff = CMP_W'(MAX_COLS);
		end else begin
			cols_eff = cols_wide;
		end
		rows_eff = (cfg.rows == '0) ? ROW_W'(1) : cfg.rows;
		end_row  = (CMP_W'(col_q) + CMP_W'(1)) == cols_eff;
		last     = (row_q == rows_eff - ROW_W'(1));
	end

	mvm_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(MAX_COLS)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (COL_W'(idx)),
		.wdata (elem),
		.re    (rd_en),
		.raddr (col_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			op_valid_s1 <= 1'b0;
		end else if (cfg.clear) begin
			col_q       <= '0;
			row_q       <= '0;
			op_valid_s1 <= 1'b0;
		end else begin
			op_valid_s1 <= rd_en;
			if (rd_en) begin
				if (end_row) begin
					col_q <= '0;
					row_q <= last ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			elem_s1    <= elem;
			end_row_s1 <= end_row;
			row_s1     <= row_q;
			last_s1    <= last;
		end
	end

	assign push            = op_valid_s1;
	assign push_op.elem    = elem_s1;
	assign push_op.vec     = rdata;
	assign push_op.end_row = end_row_s1;
	assign push_op.row     = row_s1;
	assign push_op.last    = last_s1;

endmodule

// File: hdl/mvm_queue.sv
// ----------------------------------------------------------------------------
// Matrix-vector multiply operation queue
// A short first-in first-out queue between the front end and the datapath.
// ----------------------------------------------------------------------------
module mvm_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  mvm_pkg::mvm_op_t           push_op,
	input  logic                       pop,
	output logic                       q_valid,
	output mvm_pkg::mvm_op_t           q_op,
	output logic [mvm_pkg::QCNT_W-1:0] q_count
);
	import mvm_pkg::*;

	mvm_op_t             slot_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	assign q_valid = (count_q != '0);
	assign q_op    = slot_q[rd_ptr_q];
	assign q_count = count_q;

endmodule

// File: hdl/mvm_back.sv
// ----------------------------------------------------------------------------
// Matrix-vector multiply datapath
// Multiplies, accumulates with saturation and, at the end of each row, rounds
// and clamps the dot product into the output register.
// ----------------------------------------------------------------------------
module mvm_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic                          q_valid,
	input  mvm_pkg::mvm_op_t              q_op,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mvm_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                          m_tlast,
	output logic                          m_tuser
);
	import mvm_pkg::*;

	localparam int RW = ACC_W - FRAC_BITS + 1;
	localparam logic signed [RW-1:0] LIM_HI = RW'((65'sd1 <<< (VALUE_WIDTH - 1)) - 65'sd1);
	localparam logic signed [RW-1:0] LIM_LO = -LIM_HI - RW'(1);

	logic                          adv;
	logic signed [2*VALUE_WIDTH-1:0] prod;
	logic signed [ACC_W:0]         sum_wide;
	logic signed [ACC_W-1:0]       sum_sat;
	logic                          clamp;
	logic signed [RW-1:0]          rnd;
	logic signed [VALUE_WIDTH-1:0] res;
	logic                          res_clamp;

	logic                          valid_s1;
	logic signed [ACC_W-1:0]       product_s1;
	logic                          end_row_s1;
	logic [ROW_W-1:0]              row_s1;
	logic                          last_s1;

	logic                          fin_valid_s2;
	logic signed [ACC_W-1:0]       sum_s2;
	logic                          ovf_s2;
	logic [ROW_W-1:0]              row_s2;
	logic                          last_s2;

	logic signed [ACC_W-1:0]       acc_q;
	logic                          ovf_q;
	logic                          res_valid_q;
	logic [FIELD_W-1:0]            row_sum_q;
	logic [ROW_W-1:0]              row_num_q;
	logic                          last_q;
	logic                          sat_q;

	assign adv  = !res_valid_q || m_tready;
	assign pop  = adv && q_valid;
	assign prod = $signed(q_op.elem) * $signed(q_op.vec);

	always_comb begin
		sum_wide = {acc_q[ACC_W-1], acc_q} + {product_s1[ACC_W-1], product_s1};
		clamp    = sum_wide[ACC_W] != sum_wide[ACC_W-1];
		if (!clamp) begin
			sum_sat = sum_wide[ACC_W-1:0];
		end else if (sum_wide[ACC_W]) begin
			sum_sat = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			sum_sat = {1'b0, {(ACC_W-1){1'b1}}};
		end
	end

	always_comb begin
		rnd = $signed(RW'(sum_s2 >>> FRAC_BITS))
			+ $signed({{(RW-1){1'b0}}, sum_s2[FRAC_BITS-1]});
		res_clamp = ovf_s2;
		if (rnd > LIM_HI) begin
			res       = LIM_HI[VALUE_WIDTH-1:0];
			res_clamp = 1'b1;
		end else if (rnd < LIM_LO) begin
			res       = LIM_LO[VALUE_WIDTH-1:0];
			res_clamp = 1'b1;
		end else begin
			res = rnd[VALUE_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			fin_valid_s2 <= 1'b0;
			acc_q        <= '0;
			ovf_q        <= 1'b0;
			res_valid_q  <= 1'b0;
		end else if (clear) begin
			valid_s1     <= 1'b0;
			fin_valid_s2 <= 1'b0;
			acc_q        <= '0;
			ovf_q        <= 1'b0;
			res_valid_q  <= 1'b0;
		end else if (adv) begin
			valid_s1     <= q_valid;
			fin_valid_s2 <= valid_s1 && end_row_s1;
			res_valid_q  <= fin_valid_s2;
			if (valid_s1) begin
				if (end_row_s1) begin
					acc_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					acc_q <= sum_sat;
					ovf_q <= ovf_q || clamp;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (q_valid) begin
				product_s1 <= ACC_W'(prod);
				end_row_s1 <= q_op.end_row;
				row_s1     <= q_op.row;
				last_s1    <= q_op.last;
			end
			if (valid_s1 && end_row_s1) begin
				sum_s2  <= sum_sat;
				ovf_s2  <= ovf_q || clamp;
				row_s2  <= row_s1;
				last_s2 <= last_s1;
			end
			if (fin_valid_s2) begin
				row_sum_q <= FIELD_W'(res);
				row_num_q <= row_s2;
				last_q    <= last_s2;
				sat_q     <= res_clamp;
			end
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {row_num_q, row_sum_q};
	assign m_tlast  = last_q;
	assign m_tuser  = sat_q;

endmodule

// File: hdl/matrix_vector_multiply.sv
// ----------------------------------------------------------------------------
// Matrix-vector multiply
// Streams a row-major matrix against a stored vector in signed Q16.16 and
// delivers one saturated dot product per row.
//
// Load the vector first with vector words (s_tuser low), each naming a store
// position. Matrix words (s_tuser high) follow in row-major order; after the
// last column of a row one result word appears on the master side, with
// m_tlast set for the final row and m_tuser set if anything saturated.
// cols_in_use and rows_in_use are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle, which the block
// itself does not enforce; a write also restarts the product at row 0. One
// word is accepted per cycle while results are taken: the store read, the
// multiplier and the accumulator each take one word a cycle. When the
// receiver stalls, the result holds in the output register, the four-entry
// operation queue fills and s_tready then drops until the result is taken.
// Reset clears the counters, accumulator and queue; the vector store keeps
// no reset value and must be written before use.
// ----------------------------------------------------------------------------
module matrix_vector_multiply (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_index,
	input  logic [mvm_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// vector_index[9:0], element_value[41:10], zero[47:42]
	input  logic [mvm_pkg::S_TDATA_W-1:0] s_tdata,
	// command
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// row_sum[31:0], row_number[47:32]
	output logic [mvm_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                          m_tlast,
	// saturated
	output logic                          m_tuser
);
	import mvm_pkg::*;

	logic [COLS_CFG_W-1:0] cols_q;
	logic [ROW_W-1:0]      rows_q;
	mvm_cfg_t              cfg;
	logic [QCNT_W-1:0]     q_count;
	logic                  push;
	mvm_op_t               push_op;
	logic                  q_valid;
	mvm_op_t               q_op;
	logic                  pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_CFG_W'(COLS_RESET);
			rows_q <= ROW_W'(ROWS_RESET);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_COLS: cols_q <= cfg_data[COLS_CFG_W-1:0];
				REG_ROWS: rows_q <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.cols  = cols_q;
	assign cfg.rows  = rows_q;
	assign cfg.clear = cfg_we;

	mvm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_count  (q_count),
		.push     (push),
		.push_op  (push_op)
	);

	mvm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.q_valid (q_valid),
		.q_op    (q_op),
		.q_count (q_count)
	);

	mvm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (cfg_we),
		.q_valid  (q_valid),
		.q_op     (q_op),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// File: hdl/mvm_checker.sv
// ----------------------------------------------------------------------------
// Matrix-vector multiply checker
// Watches the top-level ports: result words hold while stalled, row numbers
// run in order and the final-row mark matches the configured row count.
// ----------------------------------------------------------------------------
`include "matrix_vector_multiply_macros.svh"

module mvm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_we,
	input logic [0:0]                    cfg_index,
	input logic [mvm_pkg::CFG_W-1:0]     cfg_data,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [mvm_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                          m_tlast,
	input logic                          m_tuser
);
	import mvm_pkg::*;

	logic [ROW_W-1:0] rows_q;
	logic [ROW_W-1:0] exp_row_q;
	logic [ROW_W-1:0] rows_m1;
	logic [ROW_W-1:0] row_num;

	assign row_num = m_tdata[ROWNUM_LSB +: ROW_W];
	assign rows_m1 = (rows_q == '0) ? '0 : rows_q - ROW_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q    <= ROW_W'(ROWS_RESET);
			exp_row_q <= '0;
		end else if (cfg_we) begin
			if (cfg_reg_t'(cfg_index) == REG_ROWS) begin
				rows_q <= cfg_data[ROW_W-1:0];
			end
			exp_row_q <= '0;
		end else if (m_tvalid && m_tready) begin
			exp_row_q <= m_tlast ? '0 : row_num + ROW_W'(1);
		end
	end

	`MVM_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "result word changed while stalled")
	`MVM_ASSERT_IMP(a_last_row, m_tvalid, m_tlast == (row_num == rows_m1), "final-row mark does not match row count")
	`MVM_ASSERT_IMP(a_row_order, m_tvalid && m_tready, row_num == exp_row_q, "row results out of order")

endmodule

bind matrix_vector_multiply mvm_checker u_checker (.*);

// File: bench/mvm_row_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Row result checker for the matrix-vector multiply
// Watches the configuration port and both stream channels, keeps its own
// copy of the vector store and accumulator, predicts every row result and
// compares each delivered word with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module mvm_row_checker
	import mvm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 m_tlast,
	input  logic                 m_tuser,
	input  logic                 end_of_test,
	output int                   errors,
	output int                   pending,
	output int                   rows_checked,
	output int                   rows_saturated
);

	typedef struct {
		logic [FIELD_W-1:0] row_sum;
		logic [ROW_W-1:0]   row_number;
		logic               last_row;
		logic               saturated;
	} row_result_t;

	row_result_t            row_sums_due[$];
	logic [VALUE_WIDTH-1:0] vector_copy [MAX_COLS];
	longint                 running_sum;
	int unsigned            col_pos;
	logic [ROW_W-1:0]       row_pos;
	logic                   clamp_seen;
	logic [COLS_CFG_W-1:0]  cols_reg;
	logic [ROW_W-1:0]       rows_reg;
	bit                     closed;

	task automatic flag(input string msg);
		$display("%0t ns: %s", $time, msg);
		errors++;
	endtask

	task automatic restart_product();
		running_sum = 0;
		col_pos     = 0;
		row_pos     = '0;
		clamp_seen  = 1'b0;
	endtask

	task automatic take_config();
		case (cfg_reg_t'(cfg_index))
			REG_COLS: begin
				cols_reg = cfg_data[COLS_CFG_W-1:0];
			end
			REG_ROWS: begin
				rows_reg = cfg_data[ROW_W-1:0];
			end
			default: begin
			end
		endcase
		restart_product();
	endtask

	task automatic accumulate_element(input logic [VALUE_WIDTH-1:0] elem);
		int unsigned      cols;
		logic [ROW_W-1:0] rows;
		longint           product;
		longint           total;
		longint           rounded;
		longint           lim_hi;
		longint           lim_lo;
		row_result_t      res;
		cols = (cols_reg == 0) ? 1 : (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
		rows = (rows_reg == 0) ? ROW_W'(1) : rows_reg;
		if (col_pos >= cols) begin
			col_pos = cols - 1;
		end
		product = longint'($signed(elem)) * longint'($signed(vector_copy[col_pos]));
		total = running_sum + product;
		if (running_sum[63] == product[63] && total[63] != running_sum[63]) begin
			total = running_sum[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
			clamp_seen = 1'b1;
		end
		running_sum = total;
		if (col_pos + 1 < cols) begin
			col_pos++;
		end else begin
			rounded = (running_sum >>> FRAC_BITS) + (running_sum[FRAC_BITS-1] ? 64'sd1 : 64'sd0);
			lim_hi = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
			lim_lo = -lim_hi - 64'sd1;
			res.saturated = clamp_seen;
			if (rounded > lim_hi) begin
				rounded = lim_hi;
				res.saturated = 1'b1;
			end else if (rounded < lim_lo) begin
				rounded = lim_lo;
				res.saturated = 1'b1;
			end
			res.row_sum    = rounded[FIELD_W-1:0];
			res.row_number = row_pos;
			res.last_row   = (row_pos == rows - 1'b1);
			row_sums_due.push_back(res);
			running_sum = 0;
			col_pos     = 0;
			clamp_seen  = 1'b0;
			row_pos     = res.last_row ? '0 : row_pos + 1'b1;
		end
	endtask

	task automatic check_result();
		row_result_t        want;
		logic [FIELD_W-1:0] got_sum;
		logic [ROW_W-1:0]   got_row;
		got_sum = m_tdata[ROWSUM_LSB +: FIELD_W];
		got_row = m_tdata[ROWNUM_LSB +: ROW_W];
		if (row_sums_due.size() == 0) begin
			flag($sformatf("unexpected row result: row_sum %h row_number %0d", got_sum, got_row));
		end else begin
			want = row_sums_due.pop_front();
			rows_checked++;
			if (want.saturated) begin
				rows_saturated++;
			end
			if (got_sum !== want.row_sum) begin
				flag($sformatf("row %0d: row_sum %h, expected %h",
					want.row_number, got_sum, want.row_sum));
			end
			if (got_row !== want.row_number) begin
				flag($sformatf("row_number %0d, expected %0d", got_row, want.row_number));
			end
			if (m_tlast !== want.last_row) begin
				flag($sformatf("row %0d: last_row %b, expected %b",
					want.row_number, m_tlast, want.last_row));
			end
			if (m_tuser !== want.saturated) begin
				flag($sformatf("row %0d: saturated %b, expected %b",
					want.row_number, m_tuser, want.saturated));
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			row_sums_due.delete();
			cols_reg = COLS_CFG_W'(COLS_RESET);
			rows_reg = ROW_W'(ROWS_RESET);
			restart_product();
			closed = 1'b0;
		end else begin
			if (cfg_we) begin
				take_config();
			end
			if (s_tvalid && s_tready) begin
				if (cmd_t'(s_tuser) == CMD_VECTOR) begin
					vector_copy[s_tdata[IDX_LSB +: IDX_W]] = s_tdata[VAL_LSB +: VALUE_WIDTH];
				end else begin
					accumulate_element(s_tdata[VAL_LSB +: VALUE_WIDTH]);
				end
			end
			if (m_tvalid && m_tready) begin
				check_result();
			end
			if (end_of_test && !closed) begin
				closed = 1'b1;
				if (row_sums_due.size() != 0) begin
					flag($sformatf("%0d row results never arrived", row_sums_due.size()));
				end
			end
		end
		pending <= row_sums_due.size();
	end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Matrix-vector multiply testbench
// Loads the vector store, streams matrix words under many column and row
// settings with random gaps on both sides, and leaves every prediction and
// comparison to the row checker.
// ----------------------------------------------------------------------------
module tb_top;
	import mvm_pkg::*;

	localparam int SETTLE_CYCLES = 12;
	localparam int DRAIN_LIMIT   = 2000;
	localparam int RANDOM_WORDS  = 1600;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_we      = 1'b0;
	logic [0:0]           cfg_index   = REG_COLS;
	logic [CFG_W-1:0]     cfg_data    = '0;
	logic                 s_tvalid    = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata     = '0;
	logic                 s_tuser     = CMD_VECTOR;
	logic                 m_tvalid;
	logic                 m_tready    = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tlast;
	logic                 m_tuser;
	logic                 end_of_test = 1'b0;

	int errors;
	int pending;
	int rows_checked;
	int rows_saturated;

	bit burst;
	bit loaded [MAX_COLS];
	int words_sent;
	int settings;
	int sink_hold;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	matrix_vector_multiply dut (.*);

	mvm_row_checker u_row_checker (.*);

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

	always @(posedge clk) begin : result_sink
		int stall;
		if (!arst_n) begin
			m_tready  <= 1'b0;
			sink_hold <= 0;
		end else if (m_tready && m_tvalid) begin
			stall = burst ? 0 : $urandom_range(0, 7);
			sink_hold <= stall;
			m_tready  <= (stall == 0);
		end else if (!m_tready) begin
			if (sink_hold <= 1) begin
				m_tready <= 1'b1;
			end
			sink_hold <= sink_hold - 1;
		end
	end

	function automatic logic [VALUE_WIDTH-1:0] pick_value();
		logic [19:0] mid;
		mid = 20'($urandom);
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($urandom_range(0, 8)) - 32'd4;
			3, 4, 5, 6: return {{12{mid[19]}}, mid};
			default: return $urandom;
		endcase
	endfunction

	function automatic int eff_cols(input logic [CFG_W-1:0] cols_data);
		int c;
		c = cols_data[COLS_CFG_W-1:0];
		return (c == 0) ? 1 : (c > MAX_COLS) ? MAX_COLS : c;
	endfunction

	task automatic send_word(input cmd_t cmd, input logic [IDX_W-1:0] idx,
			input logic [VALUE_WIDTH-1:0] val);
		int                   gap;
		logic [S_TDATA_W-1:0] word;
		gap  = burst ? 0 : $urandom_range(0, 7);
		word = '0;
		word[IDX_LSB +: IDX_W]       = idx;
		word[VAL_LSB +: VALUE_WIDTH] = val;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= word;
		do @(posedge clk); while (s_tready !== 1'b1);
		words_sent++;
	endtask

	task automatic load_vector(input logic [IDX_W-1:0] idx, input logic [VALUE_WIDTH-1:0] val);
		send_word(CMD_VECTOR, idx, val);
		loaded[idx] = 1'b1;
	endtask

	task automatic send_element(input logic [VALUE_WIDTH-1:0] val);
		send_word(CMD_MATRIX, IDX_W'($urandom), val);
	endtask

	// Matrix words with the odd vector write slipped in between them.
	task automatic run_matrix(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				load_vector(IDX_W'($urandom), pick_value());
			end
			send_element(pick_value());
		end
	endtask

	// Every entry a row will read must have been written at least once.
	task automatic prime_store(input int cols);
		for (int i = 0; i < cols; i++) begin
			if (!loaded[i] || $urandom_range(0, 7) == 0) begin
				load_vector(IDX_W'(i), pick_value());
			end
		end
	endtask

	task automatic settle();
		int n;
		s_tvalid <= 1'b0;
		@(posedge clk);
		for (n = 0; n < DRAIN_LIMIT && pending != 0; n++) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_shape(input logic [CFG_W-1:0] cols_data,
			input logic [CFG_W-1:0] rows_data, input bit cols_first);
		cfg_we    <= 1'b1;
		cfg_index <= cols_first ? REG_COLS : REG_ROWS;
		cfg_data  <= cols_first ? cols_data : rows_data;
		@(posedge clk);
		cfg_index <= cols_first ? REG_ROWS : REG_COLS;
		cfg_data  <= cols_first ? rows_data : cols_data;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	initial begin
		logic [COLS_CFG_W-1:0] cols;
		logic [ROW_W-1:0]      rows;
		logic [CFG_W-1:0]      cols_data;
		int                    cols_eff;
		int                    rows_eff;
		int                    row_runs;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Two columns, three rows: accumulator clamp, output clamp, a tie
		// rounding upwards with a vector write mid-row, then a wrap to row 0.
		write_shape(16'd2, 16'd3, 1'b1);
		load_vector(10'd0, 32'h8000_0000);
		load_vector(10'd1, 32'h8000_0000);
		send_element(32'h8000_0000);
		send_element(32'h8000_0000);
		send_element(32'h7FFF_FFFF);
		send_element(32'h7FFF_FFFF);
		load_vector(10'd1, 32'h0000_8000);
		send_element(32'h0000_0000);
		load_vector(10'd0, 32'h1234_5678);
		send_element(32'h0000_0001);
		send_element(32'hFFFF_FFFF);
		send_element(32'hFFFF_FFFF);
		load_vector(10'h3FF, 32'hA5A5_5A5A);
		settle();

		// Zero column and row counts act as one; a negative tie rounds to zero.
		write_shape(16'hF800, 16'd0, 1'b0);
		load_vector(10'd0, 32'h0000_8000);
		send_element(32'hFFFF_FFFF);
		send_element(32'h7FFF_FFFF);
		settle();

		while (words_sent < RANDOM_WORDS) begin
			burst = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 11))
				0: cols = '0;
				1: cols = 11'd1;
				8, 9: cols = COLS_CFG_W'($urandom_range(9, 40));
				10: cols = COLS_CFG_W'($urandom_range(41, 160));
				default: cols = COLS_CFG_W'($urandom_range(2, 8));
			endcase
			case ($urandom_range(0, 9))
				0: rows = '0;
				1: rows = 16'd1;
				8: rows = 16'hFFFF;
				9: rows = ROW_W'($urandom_range(6, 65534));
				default: rows = ROW_W'($urandom_range(2, 5));
			endcase
			cols_data = {5'($urandom), cols};
			cols_eff  = eff_cols(cols_data);
			rows_eff  = (rows == 0) ? 1 : rows;
			row_runs  = $urandom_range(1, 2 * ((rows_eff < 4) ? rows_eff : 4) + 1);
			write_shape(cols_data, rows, bit'($urandom_range(0, 1)));
			prime_store(cols_eff);
			run_matrix(row_runs * cols_eff);
			if (cols_eff > 1 && $urandom_range(0, 3) == 0) begin
				run_matrix($urandom_range(1, cols_eff - 1));
			end
			settle();
		end

		end_of_test <= 1'b1;
		repeat (2) @(posedge clk);
		$display("Covered %0d input words under %0d register settings.", words_sent, settings);
		$display("Checked %0d row results, %0d of them saturated.", rows_checked, rows_saturated);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
